/* design/hpq_pkg.sv */
// Shared types, codes and constants for the binary heap priority queue.
package hpq_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  localparam int OUT_TOP_LO    = 0;
  localparam int OUT_TOP_HI    = 31;
  localparam int OUT_COUNT_LO  = 32;
  localparam int OUT_COUNT_HI  = 42;
  localparam int OUT_EMPTY     = 43;
  localparam int OUT_STATUS_LO = 44;
  localparam int OUT_STATUS_HI = 45;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CFG_SEL_HEAP_ORDER = 1'b0;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
    logic [VALUE_W-1:0]  top_value;
  } result_t;

endpackage

/* design/hpq_mem.sv */
// Heap storage: one write port, two registered read ports.
module hpq_mem #(
  parameter int DEPTH = hpq_pkg::CAPACITY_DEF,
  parameter int WIDTH = hpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

/* design/hpq_engine.sv */
// Command sequencer: push sift-up, pop sift-down and clear over the heap memory.
module hpq_engine #(
  parameter int CAPACITY   = hpq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = hpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hpq_pkg::CMD_W-1:0]     cmd,
  input  logic [hpq_pkg::VALUE_W-1:0]   value,
  input  logic                          order,
  output logic                          in_ready,
  output logic                          res_valid,
  input  logic                          res_ready,
  output hpq_pkg::result_t              res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POP_RD = 3'd1;
  localparam logic [2:0] S_POP_LD = 3'd2;
  localparam logic [2:0] S_UP_RD  = 3'd3;
  localparam logic [2:0] S_UP_CMP = 3'd4;
  localparam logic [2:0] S_DN_RD  = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_PLACE  = 3'd7;

  logic [2:0]                     state_r, state_nxt;
  logic                           fin_r, fin_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0]          val_r, val_nxt;
  logic [DATA_WIDTH-1:0]          top_r, top_nxt;
  logic [hpq_pkg::STATUS_W-1:0]   status_r, status_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr_a, rd_addr_b;
  logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;

  logic [DATA_WIDTH+hpq_pkg::VALUE_W-1:0] value_wide;
  logic [DATA_WIDTH-1:0]                  value_in;
  logic [DATA_WIDTH+hpq_pkg::VALUE_W-1:0] top_wide;
  logic [CW+hpq_pkg::COUNT_W-1:0]         count_wide;
  logic [AW-1:0]         parent;
  logic [IW-1:0]         left_w, right_w, n_w;
  logic                  leaf, right_ok, full, pick_right;
  logic [AW-1:0]         best_idx;
  logic [DATA_WIDTH-1:0] best_val;

  function automatic logic ranks_above(input logic [DATA_WIDTH-1:0] a,
                                       input logic [DATA_WIDTH-1:0] b,
                                       input logic                  ord);
    return ord ? (a < b) : (a > b);
  endfunction

  hpq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign value_wide = {{DATA_WIDTH{1'b0}}, value};
  assign value_in   = value_wide[DATA_WIDTH-1:0];
  assign parent     = AW'(idx_r - AW'(1)) >> 1;
  assign left_w     = {1'b0, idx_r, 1'b1};
  assign right_w    = left_w + IW'(1);
  assign n_w        = IW'(count_r);
  assign leaf       = left_w >= n_w;
  assign right_ok   = right_w < n_w;
  assign full       = count_r >= CW'(CAPACITY);
  assign pick_right = right_ok && ranks_above(rd_data_b, rd_data_a, order);
  assign best_idx   = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign best_val   = pick_right ? rd_data_b : rd_data_a;

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    top_nxt    = top_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = val_r;
    rd_addr_a  = '0;
    rd_addr_b  = '0;
    res_valid  = 1'b0;
    if (fin_r) begin
      res_valid = 1'b1;
      if (res_ready) begin
        fin_nxt = 1'b0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            status_nxt = hpq_pkg::STAT_OK;
            unique case (cmd)
              hpq_pkg::CMD_PUSH: begin
                if (full) begin
                  status_nxt = hpq_pkg::STAT_FULL;
                  fin_nxt    = 1'b1;
                end else begin
                  val_nxt   = value_in;
                  idx_nxt   = count_r[AW-1:0];
                  count_nxt = count_r + CW'(1);
                  state_nxt = (count_r == '0) ? S_PLACE : S_UP_RD;
                end
              end
              hpq_pkg::CMD_POP: begin
                if (count_r == '0) begin
                  status_nxt = hpq_pkg::STAT_EMPTY;
                  fin_nxt    = 1'b1;
                end else begin
                  count_nxt = count_r - CW'(1);
                  if (count_r == CW'(1)) begin
                    fin_nxt = 1'b1;
                  end else begin
                    state_nxt = S_POP_RD;
                  end
                end
              end
              hpq_pkg::CMD_CLEAR: begin
                count_nxt = '0;
                fin_nxt   = 1'b1;
              end
              default: begin
                fin_nxt = 1'b1;
              end
            endcase
          end
        end
        S_POP_RD: begin
          rd_addr_a = count_r[AW-1:0];
          state_nxt = S_POP_LD;
        end
        S_POP_LD: begin
          val_nxt   = rd_data_a;
          idx_nxt   = '0;
          state_nxt = S_DN_RD;
        end
        S_UP_RD: begin
          rd_addr_a = parent;
          state_nxt = S_UP_CMP;
        end
        S_UP_CMP: begin
          if (ranks_above(val_r, rd_data_a, order)) begin
            wr_en     = 1'b1;
            wr_data   = rd_data_a;
            idx_nxt   = parent;
            state_nxt = (parent == '0) ? S_PLACE : S_UP_RD;
          end else begin
            state_nxt = S_PLACE;
          end
        end
        S_DN_RD: begin
          rd_addr_a = left_w[AW-1:0];
          rd_addr_b = right_w[AW-1:0];
          state_nxt = leaf ? S_PLACE : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (ranks_above(best_val, val_r, order)) begin
            wr_en     = 1'b1;
            wr_data   = best_val;
            idx_nxt   = best_idx;
            state_nxt = S_DN_RD;
            if (idx_r == '0) begin
              top_nxt = best_val;
            end
          end else begin
            state_nxt = S_PLACE;
          end
        end
        S_PLACE: begin
          wr_en     = 1'b1;
          state_nxt = S_IDLE;
          fin_nxt   = 1'b1;
          if (idx_r == '0) begin
            top_nxt = val_r;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = !fin_r && (state_r == S_IDLE);

  assign top_wide   = {{hpq_pkg::VALUE_W{1'b0}}, top_r};
  assign count_wide = {{hpq_pkg::COUNT_W{1'b0}}, count_r};

  always_comb begin
    res.top_value   = (count_r != '0) ? top_wide[hpq_pkg::VALUE_W-1:0] : '0;
    res.entry_count = count_wide[hpq_pkg::COUNT_W-1:0];
    res.is_empty    = (count_r == '0);
    res.status      = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fin_r    <= 1'b0;
      count_r  <= '0;
      status_r <= hpq_pkg::STAT_OK;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    top_r <= top_nxt;
  end

endmodule

/* design/binary_heap_priority_queue.sv */
// Top level of the binary heap priority queue: stream channels, register port, result register.
//
// Input channel (in_*): one command per transaction; in_tuser carries the command
// (push, pop, clear) and in_tdata the value to push. Result channel (out_*): one
// result per command with the top value, entry count, empty flag and status.
// Register port (cfg_*): byte address 0 holds heap_order (0 largest on top,
// 1 smallest on top); write it only while the queue is idle.
// Command steps: clear, rejected and trivial commands finish straight from idle.
// A push reads the parent (S_UP_RD) and compares and moves it down (S_UP_CMP)
// per parent compared, then writes its value (S_PLACE). A pop reads the last
// entry (S_POP_RD, S_POP_LD), then per level reads both children (S_DN_RD) and
// compares and moves the winner up (S_DN_CMP), ending in S_PLACE. Each level
// costs one read of the heap memory and one compare-and-write step.
// One command is in flight at a time; in_tready rises again as soon as the
// result has moved into the output register.
// Reset empties the queue and selects largest-first order; memory contents are
// not cleared. While out_tready is low the result holds and one finished
// command may wait behind it inside the sequencer.
module binary_heap_priority_queue #(
  parameter int CAPACITY   = hpq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = hpq_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hpq_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic [hpq_pkg::IN_TUSER_W-1:0]   in_tuser,   // [1:0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] top_value, [42:32] entry_count, [43] is_empty, [45:44] status, [47:46] zero
  output logic [hpq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [hpq_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [hpq_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [hpq_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  logic             order_r;
  logic             out_valid_r;
  logic [hpq_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic             eng_ready;
  logic             res_valid;
  logic             res_ready;
  hpq_pkg::result_t res;
  logic             cfg_wr;

  hpq_engine #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && eng_ready),
    .cmd       (in_tuser),
    .value     (in_tdata),
    .order     (order_r),
    .in_ready  (eng_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_tready  = eng_ready;
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == hpq_pkg::CFG_SEL_HEAP_ORDER);
  assign cfg_prdata = (cfg_paddr[2] == hpq_pkg::CFG_SEL_HEAP_ORDER) ?
                      {{(hpq_pkg::CFG_DATA_W-1){1'b0}}, order_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        order_r <= cfg_pwdata[0];
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      out_data_r <= {2'b00, res.status, res.is_empty, res.entry_count, res.top_value};
    end
  end

endmodule

/* design/hpq_checker.sv */
// Port-level checks for the binary heap priority queue, bound to the top level.
module hpq_checker #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hpq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [hpq_pkg::COUNT_W-1:0]  cnt;
  logic [hpq_pkg::STATUS_W-1:0] stat;

  assign cnt  = out_tdata[hpq_pkg::OUT_COUNT_HI:hpq_pkg::OUT_COUNT_LO];
  assign stat = out_tdata[hpq_pkg::OUT_STATUS_HI:hpq_pkg::OUT_STATUS_LO];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[hpq_pkg::OUT_EMPTY] == (cnt == '0)) &&
                   (!out_tdata[hpq_pkg::OUT_EMPTY] ||
                    out_tdata[hpq_pkg::OUT_TOP_HI:hpq_pkg::OUT_TOP_LO] == '0))
    else $error("empty flag, count and top disagree");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> stat != hpq_pkg::STAT_UNUSED &&
                   (stat != hpq_pkg::STAT_FULL || cnt >= hpq_pkg::COUNT_W'(CAPACITY)) &&
                   (stat != hpq_pkg::STAT_EMPTY || cnt == '0))
    else $error("status does not match count");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_heap_priority_queue hpq_checker #(
  .CAPACITY (CAPACITY)
) u_hpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* bench/tb_binary_heap_priority_queue.sv */
// Testbench for the binary heap priority queue: directed and random commands, self-checked.
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue;

  localparam int DEPTH = hpq_pkg::CAPACITY_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [hpq_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [hpq_pkg::CFG_ADDR_W-1:0] ADDR_HEAP_ORDER = 3'd0;
  localparam logic ORDER_LARGEST = 1'b0;
  localparam logic ORDER_SMALLEST = 1'b1;

  class heap_tracker;
    logic [hpq_pkg::VALUE_W-1:0] slots [DEPTH];
    int unsigned fill;
    logic smallest_first;
    hpq_pkg::result_t awaited[$];
    int unsigned mismatches;

    function new();
      fill = 0;
      smallest_first = ORDER_LARGEST;
      mismatches = 0;
    endfunction

    function bit outranks(logic [hpq_pkg::VALUE_W-1:0] a, logic [hpq_pkg::VALUE_W-1:0] b);
      return smallest_first ? (a < b) : (a > b);
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [hpq_pkg::VALUE_W-1:0] t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void note_command(logic [hpq_pkg::CMD_W-1:0] cmd,
                               logic [hpq_pkg::VALUE_W-1:0] value);
      hpq_pkg::result_t r;
      int unsigned idx;
      int unsigned parent;
      int unsigned left;
      int unsigned best;
      bit done;
      r.status = hpq_pkg::STAT_OK;
      done = 0;
      case (cmd)
        hpq_pkg::CMD_PUSH: begin
          if (fill >= DEPTH) begin
            r.status = hpq_pkg::STAT_FULL;
          end else begin
            slots[fill] = value;
            idx = fill;
            fill++;
            while (idx > 0 && !done) begin
              parent = (idx - 1) / 2;
              if (!outranks(slots[idx], slots[parent])) begin
                done = 1;
              end else begin
                swap_slots(idx, parent);
                idx = parent;
              end
            end
          end
        end
        hpq_pkg::CMD_POP: begin
          if (fill == 0) begin
            r.status = hpq_pkg::STAT_EMPTY;
          end else begin
            slots[0] = slots[fill - 1];
            fill--;
            idx = 0;
            while (!done) begin
              left = 2 * idx + 1;
              if (left >= fill) begin
                done = 1;
              end else begin
                best = left;
                if (left + 1 < fill && outranks(slots[left + 1], slots[left])) best = left + 1;
                if (!outranks(slots[best], slots[idx])) begin
                  done = 1;
                end else begin
                  swap_slots(idx, best);
                  idx = best;
                end
              end
            end
          end
        end
        hpq_pkg::CMD_CLEAR: fill = 0;
        default: ;
      endcase
      r.top_value = (fill > 0) ? slots[0] : '0;
      r.entry_count = fill[hpq_pkg::COUNT_W-1:0];
      r.is_empty = (fill == 0);
      awaited.push_back(r);
    endfunction

    function void check_result(hpq_pkg::result_t got);
      hpq_pkg::result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none awaited: top=%h count=%0d empty=%0b status=%0d",
                   $realtime, got.top_value, got.entry_count, got.is_empty, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.top_value !== want.top_value || got.entry_count !== want.entry_count ||
          got.is_empty !== want.is_empty || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch: want top=%h count=%0d empty=%0b status=%0d, ",
                    "got top=%h count=%0d empty=%0b status=%0d"},
                   $realtime, want.top_value, want.entry_count, want.is_empty, want.status,
                   got.top_value, got.entry_count, got.is_empty, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hpq_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // [31:0] value
  logic [hpq_pkg::IN_TUSER_W-1:0] in_tuser = '0;   // [1:0] cmd
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [31:0] top_value, [42:32] entry_count, [43] is_empty, [45:44] status, [47:46] zero
  logic [hpq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [hpq_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [hpq_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [hpq_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  heap_tracker tracker;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  binary_heap_priority_queue i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end
    stall_left--;
    case (stall_mode)
      0, 1: out_tready <= 1'b1;
      2: out_tready <= ($urandom_range(0, 1) == 0);
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        tracker.check_result(
          hpq_pkg::result_t'(out_tdata[hpq_pkg::OUT_STATUS_HI:hpq_pkg::OUT_TOP_LO]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_command(logic [hpq_pkg::CMD_W-1:0] cmd,
                              logic [hpq_pkg::VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    tracker.note_command(cmd, value);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_heap_order(logic order);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_HEAP_ORDER;
    cfg_pwdata <= {{(hpq_pkg::CFG_DATA_W-1){1'b0}}, order};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracker.smallest_first = order;
    @(posedge clk);
  endtask

  function automatic logic [hpq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [hpq_pkg::CMD_W-1:0] pick_command(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return hpq_pkg::CMD_PUSH;
    if (roll < push_pct + pop_pct) return hpq_pkg::CMD_POP;
    return ($urandom_range(0, 1) == 0) ? hpq_pkg::CMD_CLEAR : CMD_SPARE;
  endfunction

  task automatic run_mixed(int count, int push_pct, int pop_pct);
    repeat (count) send_command(pick_command(push_pct, pop_pct), pick_value());
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_heap_order(ORDER_LARGEST);
    send_command(hpq_pkg::CMD_POP, 32'h1234_5678);
    send_command(hpq_pkg::CMD_CLEAR, '0);
    send_command(CMD_SPARE, '1);
    send_command(hpq_pkg::CMD_PUSH, '0);
    send_command(hpq_pkg::CMD_PUSH, '1);
    send_command(hpq_pkg::CMD_PUSH, 32'd7);
    send_command(hpq_pkg::CMD_PUSH, 32'd7);
    send_command(hpq_pkg::CMD_PUSH, 32'd7);
    send_command(hpq_pkg::CMD_PUSH, 32'h8000_0000);
    send_command(CMD_SPARE, 32'h5555_5555);
    send_command(hpq_pkg::CMD_POP, '0);
    send_command(hpq_pkg::CMD_POP, '0);
    send_command(hpq_pkg::CMD_POP, '0);
    send_command(hpq_pkg::CMD_PUSH, 32'h5555_5555);
    send_command(hpq_pkg::CMD_PUSH, 32'hAAAA_AAAA);
    send_command(hpq_pkg::CMD_CLEAR, '1);
    send_command(hpq_pkg::CMD_POP, '0);
    drain_results();

    write_heap_order(ORDER_SMALLEST);
    send_command(hpq_pkg::CMD_PUSH, 32'd9);
    send_command(hpq_pkg::CMD_PUSH, '1);
    send_command(hpq_pkg::CMD_PUSH, '0);
    send_command(hpq_pkg::CMD_PUSH, 32'd3);
    send_command(hpq_pkg::CMD_PUSH, 32'd3);
    send_command(hpq_pkg::CMD_POP, '0);
    send_command(hpq_pkg::CMD_POP, '0);
    run_mixed(40, 60, 36);
    drain_results();

    // flip the order with entries still stored, then fill to capacity
    write_heap_order(ORDER_LARGEST);
    while (tracker.fill < DEPTH)
      send_command(($urandom_range(0, 99) < 96) ? hpq_pkg::CMD_PUSH :
                   (($urandom_range(0, 1) == 0) ? hpq_pkg::CMD_POP : CMD_SPARE),
                   pick_value());
    repeat (4) send_command(hpq_pkg::CMD_PUSH, pick_value());
    run_mixed(24, 20, 79);
    send_command(hpq_pkg::CMD_CLEAR, '0);
    drain_results();

    write_heap_order(ORDER_SMALLEST);
    run_mixed(30, 45, 51);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/hpq_pkg.sv
design/hpq_mem.sv
design/hpq_engine.sv
design/binary_heap_priority_queue.sv
design/hpq_checker.sv
bench/tb_binary_heap_priority_queue.sv
